// File: rtl/tlb_fifo_lru_replacement_top_defines.svh
// Assertion helpers used by tlbfl_back.
`ifndef TLB_FIFO_LRU_REPLACEMENT_TOP_DEFINES_SVH
`define TLB_FIFO_LRU_REPLACEMENT_TOP_DEFINES_SVH

`define TLBFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define TLBFL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/tlbfl_pkg.sv
package tlbfl_pkg;

  localparam int MaxEntriesDef = 16;

  localparam int PidW   = 16;
  localparam int SegW   = 8;
  localparam int PageW  = 10;
  localparam int FrameW = 20;
  localparam int CfgW   = 5;
  localparam int RmW    = 5;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  localparam logic [1:0] CFG_ENTRIES = 2'd0;
  localparam logic [1:0] CFG_POLICY  = 2'd1;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  localparam logic [RmW-1:0] RM_MAX = {RmW{1'b1}};

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_INSERT,
    OP_FLUSH,
    OP_NONE
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_ACT,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [PidW-1:0]   pid;
    logic [SegW-1:0]   segment;
    logic [PageW-1:0]  page;
    logic [FrameW-1:0] frame;
  } req_t;

  typedef struct packed {
    logic [PidW-1:0]   pid;
    logic [SegW-1:0]   segment;
    logic [PageW-1:0]  page;
    logic [FrameW-1:0] frame;
  } entry_t;

endpackage

// File: rtl/tlbfl_front.sv
module tlbfl_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      req_type_i,
  input  logic [tlbfl_pkg::PidW-1:0]      pid_i,
  input  logic [tlbfl_pkg::SegW-1:0]      segment_i,
  input  logic [tlbfl_pkg::PageW-1:0]     page_i,
  input  logic [tlbfl_pkg::FrameW-1:0]    frame_i,
  input  logic                            disabled_i,
  output logic                            req_valid_o,
  output tlbfl_pkg::req_t                 req_o,
  input  logic                            req_take_i
);

  tlbfl_pkg::req_t q_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  tlbfl_pkg::op_e  op;
  logic            wr_en, rd_en;

  always_comb begin
    unique case (req_type_i)
      tlbfl_pkg::REQ_LOOKUP: op = disabled_i ? tlbfl_pkg::OP_NONE : tlbfl_pkg::OP_LOOKUP;
      tlbfl_pkg::REQ_INSERT: op = disabled_i ? tlbfl_pkg::OP_NONE : tlbfl_pkg::OP_INSERT;
      tlbfl_pkg::REQ_FLUSH:  op = tlbfl_pkg::OP_FLUSH;
      default:               op = tlbfl_pkg::OP_NONE;
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = q_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = req_take_i && req_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_q[wr_ptr_q] <= '{op: op, pid: pid_i, segment: segment_i, page: page_i, frame: frame_i};
    end
  end

endmodule

// File: rtl/tlbfl_back.sv
`include "tlb_fifo_lru_replacement_top_defines.svh"

module tlbfl_back #(
  parameter int MAX_ENTRIES = tlbfl_pkg::MaxEntriesDef,
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  input  tlbfl_pkg::req_t                 req_i,
  output logic                            req_take_o,
  input  logic [CW-1:0]                   cap_i,
  input  logic                            policy_i,
  output logic                            empty,
  input  logic                            pop,
  output logic                            hit_o,
  output logic [tlbfl_pkg::FrameW-1:0]    frame_out_o,
  output logic                            evicted_o,
  output logic [tlbfl_pkg::RmW-1:0]       removed_count_o
);

  localparam int RW = IW;

  tlbfl_pkg::state_e state_q, state_d;

  tlbfl_pkg::entry_t mem [MAX_ENTRIES];
  tlbfl_pkg::entry_t rdata_q;
  tlbfl_pkg::entry_t wdata;
  logic              mem_we;
  logic [IW-1:0]     waddr;
  logic              rd_en;

  logic [CW-1:0]     rd_cnt_q, rd_cnt_d;
  logic              ex_vld_q, ex_vld_d;
  logic [IW-1:0]     ex_idx_q, ex_idx_d;
  tlbfl_pkg::req_t   cur_q, cur_d;
  logic              hit_q, hit_d;
  logic [IW-1:0]     hit_idx_q, hit_idx_d;
  logic [tlbfl_pkg::FrameW-1:0] hit_frame_q, hit_frame_d;
  logic              free_fnd_q, free_fnd_d;
  logic [IW-1:0]     free_idx_q, free_idx_d;
  logic [IW-1:0]     vic_idx_q, vic_idx_d;
  logic [tlbfl_pkg::RmW-1:0] rm_q, rm_d;

  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [RW-1:0]     load_q [MAX_ENTRIES];
  logic [RW-1:0]     load_d [MAX_ENTRIES];
  logic [RW-1:0]     use_q  [MAX_ENTRIES];
  logic [RW-1:0]     use_d  [MAX_ENTRIES];

  logic              ld_cl_en, us_cl_en;
  logic [RW-1:0]     ld_cl_r, us_cl_r;
  logic [IW-1:0]     ld_cl_skip, us_cl_skip;
  logic              ld_set_en, us_set_en;
  logic [IW-1:0]     ld_set_idx, us_set_idx;
  logic [RW-1:0]     ld_set_val, us_set_val;

  logic              res_hit_q, res_hit_d;
  logic [tlbfl_pkg::FrameW-1:0] res_frame_q, res_frame_d;
  logic              res_evicted_q, res_evicted_d;
  logic [tlbfl_pkg::RmW-1:0] res_rm_q, res_rm_d;

  logic              out_vld_q, out_vld_d;
  logic              out_hit_q, out_hit_d;
  logic [tlbfl_pkg::FrameW-1:0] out_frame_q, out_frame_d;
  logic              out_evicted_q, out_evicted_d;
  logic [tlbfl_pkg::RmW-1:0] out_rm_q, out_rm_d;

  logic              ex_v, key_m, pid_m;
  logic [RW-1:0]     ex_ord;
  logic [RW-1:0]     newest;

  assign rd_en  = (state_q == tlbfl_pkg::ST_SWEEP) && (rd_cnt_q < CW'(MAX_ENTRIES));
  assign ex_v   = valid_q[ex_idx_q];
  assign pid_m  = ex_v && (rdata_q.pid == cur_q.pid);
  assign key_m  = pid_m && (rdata_q.segment == cur_q.segment) && (rdata_q.page == cur_q.page);
  assign ex_ord = (policy_i == tlbfl_pkg::POLICY_LRU) ? use_q[ex_idx_q] : load_q[ex_idx_q];
  assign newest = RW'(cnt_q - 1'b1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tlbfl_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          state_d = (req_i.op == tlbfl_pkg::OP_NONE) ? tlbfl_pkg::ST_DONE : tlbfl_pkg::ST_SWEEP;
        end
      end
      tlbfl_pkg::ST_SWEEP: begin
        if (ex_vld_q && ex_idx_q == IW'(MAX_ENTRIES - 1)) begin
          state_d = tlbfl_pkg::ST_ACT;
        end
      end
      tlbfl_pkg::ST_ACT: state_d = tlbfl_pkg::ST_DONE;
      tlbfl_pkg::ST_DONE: begin
        if (!out_vld_q || pop) begin
          state_d = tlbfl_pkg::ST_IDLE;
        end
      end
      default: state_d = tlbfl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_take_o = (state_q == tlbfl_pkg::ST_IDLE);
    empty      = !out_vld_q;
    hit_o      = out_hit_q;
    frame_out_o = out_frame_q;
    evicted_o  = out_evicted_q;
    removed_count_o = out_rm_q;
  end

  always_comb begin
    rd_cnt_d = rd_cnt_q;
    ex_vld_d = 1'b0;
    ex_idx_d = ex_idx_q;
    cur_d = cur_q;
    hit_d = hit_q;
    hit_idx_d = hit_idx_q;
    hit_frame_d = hit_frame_q;
    free_fnd_d = free_fnd_q;
    free_idx_d = free_idx_q;
    vic_idx_d = vic_idx_q;
    rm_d = rm_q;
    valid_d = valid_q;
    cnt_d = cnt_q;
    ld_cl_en = 1'b0; ld_cl_r = '0; ld_cl_skip = '0;
    us_cl_en = 1'b0; us_cl_r = '0; us_cl_skip = '0;
    ld_set_en = 1'b0; ld_set_idx = '0; ld_set_val = '0;
    us_set_en = 1'b0; us_set_idx = '0; us_set_val = '0;
    mem_we = 1'b0;
    waddr = '0;
    wdata = '{pid: cur_q.pid, segment: cur_q.segment, page: cur_q.page, frame: cur_q.frame};
    res_hit_d = res_hit_q;
    res_frame_d = res_frame_q;
    res_evicted_d = res_evicted_q;
    res_rm_d = res_rm_q;
    out_vld_d = out_vld_q && !pop;
    out_hit_d = out_hit_q;
    out_frame_d = out_frame_q;
    out_evicted_d = out_evicted_q;
    out_rm_d = out_rm_q;

    unique case (state_q)
      tlbfl_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          cur_d = req_i;
          hit_d = 1'b0;
          hit_idx_d = '0;
          hit_frame_d = '0;
          free_fnd_d = 1'b0;
          free_idx_d = '0;
          vic_idx_d = '0;
          rm_d = '0;
          rd_cnt_d = '0;
          res_hit_d = 1'b0;
          res_frame_d = '0;
          res_evicted_d = 1'b0;
          res_rm_d = '0;
        end
      end
      tlbfl_pkg::ST_SWEEP: begin
        ex_vld_d = rd_en;
        ex_idx_d = rd_cnt_q[IW-1:0];
        if (rd_en) begin
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        if (ex_vld_q) begin
          unique case (cur_q.op)
            tlbfl_pkg::OP_LOOKUP, tlbfl_pkg::OP_INSERT: begin
              if (key_m && !hit_q) begin
                hit_d = 1'b1;
                hit_idx_d = ex_idx_q;
                hit_frame_d = rdata_q.frame;
              end
              if (!ex_v && !free_fnd_q) begin
                free_fnd_d = 1'b1;
                free_idx_d = ex_idx_q;
              end
              if (ex_v && ex_ord == '0) begin
                vic_idx_d = ex_idx_q;
              end
            end
            tlbfl_pkg::OP_FLUSH: begin
              if (pid_m) begin
                valid_d[ex_idx_q] = 1'b0;
                cnt_d = cnt_q - 1'b1;
                ld_cl_en = 1'b1; ld_cl_r = load_q[ex_idx_q]; ld_cl_skip = ex_idx_q;
                us_cl_en = 1'b1; us_cl_r = use_q[ex_idx_q];  us_cl_skip = ex_idx_q;
                rm_d = (rm_q == tlbfl_pkg::RM_MAX) ? rm_q : rm_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      tlbfl_pkg::ST_ACT: begin
        unique case (cur_q.op)
          tlbfl_pkg::OP_LOOKUP: begin
            if (hit_q) begin
              us_cl_en = 1'b1; us_cl_r = use_q[hit_idx_q]; us_cl_skip = hit_idx_q;
              us_set_en = 1'b1; us_set_idx = hit_idx_q; us_set_val = newest;
              res_hit_d = 1'b1;
              res_frame_d = hit_frame_q;
            end
          end
          tlbfl_pkg::OP_INSERT: begin
            mem_we = 1'b1;
            if (hit_q) begin
              waddr = hit_idx_q;
              ld_cl_en = 1'b1; ld_cl_r = load_q[hit_idx_q]; ld_cl_skip = hit_idx_q;
              us_cl_en = 1'b1; us_cl_r = use_q[hit_idx_q];  us_cl_skip = hit_idx_q;
              ld_set_en = 1'b1; ld_set_idx = hit_idx_q; ld_set_val = newest;
              us_set_en = 1'b1; us_set_idx = hit_idx_q; us_set_val = newest;
            end else if (cnt_q < cap_i) begin
              waddr = free_idx_q;
              valid_d[free_idx_q] = 1'b1;
              cnt_d = cnt_q + 1'b1;
              ld_set_en = 1'b1; ld_set_idx = free_idx_q; ld_set_val = RW'(cnt_q);
              us_set_en = 1'b1; us_set_idx = free_idx_q; us_set_val = RW'(cnt_q);
            end else begin
              waddr = vic_idx_q;
              ld_cl_en = 1'b1; ld_cl_r = load_q[vic_idx_q]; ld_cl_skip = vic_idx_q;
              us_cl_en = 1'b1; us_cl_r = use_q[vic_idx_q];  us_cl_skip = vic_idx_q;
              ld_set_en = 1'b1; ld_set_idx = vic_idx_q; ld_set_val = newest;
              us_set_en = 1'b1; us_set_idx = vic_idx_q; us_set_val = newest;
              res_evicted_d = 1'b1;
            end
          end
          tlbfl_pkg::OP_FLUSH: res_rm_d = rm_q;
          default: ;
        endcase
      end
      tlbfl_pkg::ST_DONE: begin
        if (!out_vld_q || pop) begin
          out_vld_d = 1'b1;
          out_hit_d = res_hit_q;
          out_frame_d = res_frame_q;
          out_evicted_d = res_evicted_q;
          out_rm_d = res_rm_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      load_d[j] = load_q[j];
      use_d[j]  = use_q[j];
      if (ld_cl_en && IW'(j) != ld_cl_skip && valid_q[j] && load_q[j] > ld_cl_r) begin
        load_d[j] = load_q[j] - 1'b1;
      end
      if (us_cl_en && IW'(j) != us_cl_skip && valid_q[j] && use_q[j] > us_cl_r) begin
        use_d[j] = use_q[j] - 1'b1;
      end
      if (ld_set_en && IW'(j) == ld_set_idx) begin
        load_d[j] = ld_set_val;
      end
      if (us_set_en && IW'(j) == us_set_idx) begin
        use_d[j] = us_set_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tlbfl_pkg::ST_IDLE;
      rd_cnt_q  <= '0;
      ex_vld_q  <= 1'b0;
      valid_q   <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_cnt_q  <= rd_cnt_d;
      ex_vld_q  <= ex_vld_d;
      valid_q   <= valid_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ex_idx_q      <= ex_idx_d;
    cur_q         <= cur_d;
    hit_q         <= hit_d;
    hit_idx_q     <= hit_idx_d;
    hit_frame_q   <= hit_frame_d;
    free_fnd_q    <= free_fnd_d;
    free_idx_q    <= free_idx_d;
    vic_idx_q     <= vic_idx_d;
    rm_q          <= rm_d;
    res_hit_q     <= res_hit_d;
    res_frame_q   <= res_frame_d;
    res_evicted_q <= res_evicted_d;
    res_rm_q      <= res_rm_d;
    out_hit_q     <= out_hit_d;
    out_frame_q   <= out_frame_d;
    out_evicted_q <= out_evicted_d;
    out_rm_q      <= out_rm_d;
    load_q        <= load_d;
    use_q         <= use_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_cnt_q[IW-1:0]];
    end
  end

  `TLBFL_ASSERT(a_cnt_tracks_valid, cnt_q == CW'($countones(valid_q)), "count out of sync")
  `TLBFL_ASSERT_IMP(a_act_to_done, state_q == tlbfl_pkg::ST_ACT, ##1 state_q == tlbfl_pkg::ST_DONE, "act not followed by done")
  `TLBFL_ASSERT(a_hit_no_evict, !(out_vld_q && out_hit_q && out_evicted_q), "hit and evict together")
  `TLBFL_ASSERT_IMP(a_sweep_start, state_q == tlbfl_pkg::ST_SWEEP && !ex_vld_q, rd_cnt_q == '0, "sweep pipeline gap")

endmodule

// File: rtl/tlb_fifo_lru_replacement_top.sv
// Fully associative translation buffer keyed by pid, segment and page.
// Request side is a queue: drive req_type_i/pid_i/segment_i/page_i/frame_i
// and raise push; the word is taken when full is low. Two requests can wait.
// Result side is a queue too: while empty is low, hit_o/frame_out_o/
// evicted_o/removed_count_o hold the oldest result; raise pop to take it.
// Configuration: cfg_valid_i with cfg_index_i/cfg_data_i; cfg_ready_o is
// always high. Index 0 sets usable entries (0 disables), index 1 the victim
// policy (0 FIFO, 1 LRU). Write only while idle.
// Each request sweeps all MAX_ENTRIES entries through one memory read port,
// one entry per cycle, one request at a time; disabled lookups/inserts and
// unknown types skip the sweep and go straight to the result stage.
// A finished result sits in the output register while the next request is
// swept; if the receiver stalls, the engine holds its next result until the
// output register frees, and the request queue then fills and raises full.
// Reset empties both queues and invalidates all entries at once; usable
// entries go to 16 and policy to FIFO.
module tlb_fifo_lru_replacement_top #(
  parameter int MAX_ENTRIES = tlbfl_pkg::MaxEntriesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      req_type_i,
  input  logic [tlbfl_pkg::PidW-1:0]      pid_i,
  input  logic [tlbfl_pkg::SegW-1:0]      segment_i,
  input  logic [tlbfl_pkg::PageW-1:0]     page_i,
  input  logic [tlbfl_pkg::FrameW-1:0]    frame_i,
  output logic                            empty,
  input  logic                            pop,
  output logic                            hit_o,
  output logic [tlbfl_pkg::FrameW-1:0]    frame_out_o,
  output logic                            evicted_o,
  output logic [tlbfl_pkg::RmW-1:0]       removed_count_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [tlbfl_pkg::CfgW-1:0]      cfg_data_i
);

  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > tlbfl_pkg::CfgW) ? CW : tlbfl_pkg::CfgW;

  logic [tlbfl_pkg::CfgW-1:0] eiu_q, eiu_d;
  logic                       policy_q, policy_d;
  logic [CMPW-1:0]            eiu_x;
  logic [CW-1:0]              cap;
  logic                       req_valid;
  logic                       req_take;
  tlbfl_pkg::req_t            req;

  assign cfg_ready_o = 1'b1;
  assign eiu_x = CMPW'(eiu_q);
  assign cap   = (eiu_x > CMPW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(eiu_x);

  always_comb begin
    eiu_d    = eiu_q;
    policy_d = policy_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tlbfl_pkg::CFG_ENTRIES: eiu_d = cfg_data_i;
        tlbfl_pkg::CFG_POLICY:  policy_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eiu_q    <= tlbfl_pkg::CfgW'(16);
      policy_q <= tlbfl_pkg::POLICY_FIFO;
    end else begin
      eiu_q    <= eiu_d;
      policy_q <= policy_d;
    end
  end

  tlbfl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_type_i  (req_type_i),
    .pid_i       (pid_i),
    .segment_i   (segment_i),
    .page_i      (page_i),
    .frame_i     (frame_i),
    .disabled_i  (eiu_q == '0),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_take_i  (req_take)
  );

  tlbfl_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_valid),
    .req_i           (req),
    .req_take_o      (req_take),
    .cap_i           (cap),
    .policy_i        (policy_q),
    .empty           (empty),
    .pop             (pop),
    .hit_o           (hit_o),
    .frame_out_o     (frame_out_o),
    .evicted_o       (evicted_o),
    .removed_count_o (removed_count_o)
  );

endmodule
